### rtl/rci_pkg.sv
`timescale 1ns / 1ps

package rci_pkg;

    // Limb width of the split multipliers.
    localparam int LIMB_W = 32;

    // Quotient bits below the saturation point of a 32-bit signed root.
    localparam int QBITS = 31;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_AXIS_X   = 3'd3,
        CFG_AXIS_Y   = 3'd4,
        CFG_AXIS_Z   = 3'd5,
        CFG_RADIUS   = 3'd6
    } t_cfg_index;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic signed [31:0] t_plus;
        logic signed [31:0] t_minus;
        logic [1:0]         hit_status;
    } t_hit;

    typedef struct packed {
        logic par;
        logic miss;
        logic ovf_p;
        logic ovf_m;
        logic neg_p;
        logic neg_m;
    } t_root_flags;

    // Signed, saturated root from the quotient magnitude and its sign.
    function automatic logic [31:0] root_word(input logic [QBITS-1:0] q,
                                              input logic ovf, input logic neg);
        logic [31:0] mag;
        mag = {1'b0, q};
        if (ovf) begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? (~mag + 32'd1) : mag;
    endfunction

endpackage

### rtl/rci_dly.sv
`timescale 1ns / 1ps

module rci_dly #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[N-1];

endmodule

### rtl/rci_mul.sv
`timescale 1ns / 1ps

module rci_mul import rci_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 18
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
    localparam int PW = AW + BW;
    localparam int SW = LIMB_W * (NA + NB);

    logic [AW-1:0]          am;
    logic [BW-1:0]          bm;
    logic [NA*LIMB_W-1:0]   r_am;
    logic [NB*LIMB_W-1:0]   r_bm;
    logic                   r_neg1;
    logic                   r_neg2;
    logic [2*LIMB_W-1:0]    r_pp [NA*NB];
    logic [SW-1:0]          acc;
    logic signed [PW-1:0]   r_p;

    // Sign and magnitude first, then limb products, then one sum.
    assign am = i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign bm = i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am   <= (NA*LIMB_W)'(am);
            r_bm   <= (NB*LIMB_W)'(bm);
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
            r_neg2 <= r_neg1;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= r_am[i*LIMB_W +: LIMB_W] * r_bm[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (SW'(r_pp[i*NB+j]) << (LIMB_W * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg2 ? -$signed(acc[PW-1:0]) : $signed(acc[PW-1:0]);
        end
    end

    assign o_p = r_p;

endmodule

### rtl/rci_sqrt_cell.sv
`timescale 1ns / 1ps

module rci_sqrt_cell #(
    parameter int SQW = 82,
    parameter int PLW = 8
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [2*SQW-1:0]   i_rad,
    input  logic [SQW+1:0]     i_rem,
    input  logic [SQW-1:0]     i_root,
    input  logic [PLW-1:0]     i_pl,
    output logic [2*SQW-1:0]   o_rad,
    output logic [SQW+1:0]     o_rem,
    output logic [SQW-1:0]     o_root,
    output logic [PLW-1:0]     o_pl
);

    logic [SQW+3:0]   rem2;
    logic [SQW+3:0]   trial;
    logic [SQW+3:0]   diff;
    logic             ge;
    logic [2*SQW-1:0] r_rad;
    logic [SQW+1:0]   r_rem;
    logic [SQW-1:0]   r_root;
    logic [PLW-1:0]   r_pl;

    // One root bit: bring down two radicand bits and try 4*root+1.
    assign rem2  = {i_rem, i_rad[2*SQW-1 -: 2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign ge    = rem2 >= trial;
    assign diff  = rem2 - trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[2*SQW-3:0], 2'b00};
            r_rem  <= ge ? diff[SQW+1:0] : rem2[SQW+1:0];
            r_root <= {i_root[SQW-2:0], ge};
            r_pl   <= i_pl;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pl   = r_pl;

endmodule

### rtl/rci_div_cell.sv
`timescale 1ns / 1ps

module rci_div_cell import rci_pkg::*; #(
    parameter int RW  = 104,
    parameter int DVW = 79,
    parameter int K   = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RW-1:0]     i_rem,
    input  logic [DVW-1:0]    i_dvs,
    input  logic [QBITS-1:0]  i_q,
    output logic [RW-1:0]     o_rem,
    output logic [DVW-1:0]    o_dvs,
    output logic [QBITS-1:0]  o_q
);

    logic [RW-1:0]    trial;
    logic             ge;
    logic [QBITS-1:0] n_q;
    logic [RW-1:0]    r_rem;
    logic [DVW-1:0]   r_dvs;
    logic [QBITS-1:0] r_q;

    // Restoring step for quotient bit K.
    assign trial = RW'(i_dvs) << K;
    assign ge    = i_rem >= trial;

    always_comb begin
        n_q    = i_q;
        n_q[K] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? (i_rem - trial) : i_rem;
            r_dvs <= i_dvs;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_dvs = r_dvs;
    assign o_q   = r_q;

endmodule

### rtl/ray_cylinder_intersect_top.sv
`timescale 1ns / 1ps

// Ray against infinite cylinder. Each transaction on the ray channel carries one ray
// (origin and direction, signed fixed point with FRAC_BITS fraction bits) and yields
// exactly one transaction on the hit channel with both roots of the quadratic and a
// status: hit, miss (negative discriminant) or parallel (the ray has no component
// across the axis). Miss and parallel return MISS_DISTANCE in both roots; roots are
// truncated toward zero and saturated to 32 bits. A new ray is taken every cycle
// while an output queue entry is free. SQW is half the discriminant width, 82 at
// FRAC_BITS = 16. The wide multiplies are split into 32-bit limb products over three
// stages, the square root is a row of SQW cells that each settle one root bit, and
// each root is divided by a row of 31 cells, one quotient bit each. A two-entry output
// queue lets the pipeline keep accepting while a result waits; the ray channel stalls
// only when both entries are full. An index past the radius is ignored. Cylinder
// registers are written through the configuration channel, which is always ready,
// and the user must write them only while the block holds no transaction in flight (not enforced).

module ray_cylinder_intersect_top import rci_pkg::*; #(
    parameter logic [31:0] MISS_DISTANCE = 32'd2147483647,
    parameter int          FRAC_BITS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ray_valid,
    output logic                 o_ray_ready,
    input  t_ray                 i_ray,
    output logic                 o_hit_valid,
    input  logic                 i_hit_ready,
    output t_hit                 o_hit,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Widths follow the exact integer growth of every step.
    localparam int BW_IN = 32;
    localparam int XW    = 33;
    localparam int VW    = 18;
    localparam int RAD_W = 31;
    localparam int PBW   = BW_IN + VW + 2;
    localparam int PXW   = XW + VW + 2;
    localparam int QBW   = PBW - FRAC_BITS;
    localparam int QXW   = PXW - FRAC_BITS;
    localparam int SBW   = QBW + VW - FRAC_BITS;
    localparam int SXW   = QXW + VW - FRAC_BITS;
    localparam int BPW   = ((SBW > BW_IN) ? SBW : BW_IN) + 1;
    localparam int XPW   = ((SXW > XW) ? SXW : XW) + 1;
    localparam int AQW   = 2 * BPW + 2;
    localparam int HQW   = BPW + XPW + 2;
    localparam int CQW   = (((2 * XPW + 2) > (2 * RAD_W)) ? (2 * XPW + 2) : (2 * RAD_W)) + 1;
    localparam int DW    = (((2 * HQW) > (AQW + CQW)) ? (2 * HQW) : (AQW + CQW)) + 1;
    localparam int SQW   = DW / 2;
    localparam int NW    = ((HQW > SQW + 1) ? HQW : (SQW + 1)) + 1;
    localparam int MW    = NW + FRAC_BITS;
    localparam int DVW   = AQW - 1;
    localparam int RW    = (MW > DVW + QBITS) ? MW : (DVW + QBITS);
    localparam int PLW   = HQW + DVW + 2;
    localparam int LAT   = 51 + SQW;
    localparam int FLW   = $bits(t_root_flags);

    // Cylinder registers.
    logic signed [31:0]     r_center [3];
    logic signed [VW-1:0]   r_axis [3];
    logic [RAD_W-1:0]       r_radius;
    logic [2*RAD_W-1:0]     r_rad_sq;

    // Pipeline control.
    logic                   en;
    logic                   ray_acc;
    logic [LAT-1:0]         r_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
            r_axis[0]   <= '0;
            r_axis[1]   <= 18'sd65536;
            r_axis[2]   <= '0;
            r_radius    <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                CFG_AXIS_X:   r_axis[0]   <= i_cfg_data[VW-1:0];
                CFG_AXIS_Y:   r_axis[1]   <= i_cfg_data[VW-1:0];
                CFG_AXIS_Z:   r_axis[2]   <= i_cfg_data[VW-1:0];
                CFG_RADIUS:   r_radius    <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // The user must keep the radius static while rays are in flight (not enforced), so its square is simply kept.
    always_ff @(posedge i_clk) begin
        r_rad_sq <= r_radius * r_radius;
    end

    // Stage 1: direction and offset from the center.
    logic signed [BW_IN-1:0] r_b [3];
    logic signed [XW-1:0]    r_x [3];
    logic signed [BW_IN-1:0] ray_dir [3];
    logic signed [31:0]      ray_org [3];

    assign ray_dir[0] = i_ray.dir_x;
    assign ray_dir[1] = i_ray.dir_y;
    assign ray_dir[2] = i_ray.dir_z;
    assign ray_org[0] = i_ray.origin_x;
    assign ray_org[1] = i_ray.origin_y;
    assign ray_org[2] = i_ray.origin_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= ray_dir[i];
                r_x[i] <= XW'(ray_org[i]) - XW'(r_center[i]);
            end
        end
    end

    // Stages 2 to 4: dot products with the axis.
    logic signed [BW_IN+VW-1:0] p_b [3];
    logic signed [XW+VW-1:0]    p_x [3];

    // Stage 5: floor of the projected lengths.
    logic signed [PBW-1:0]   pb;
    logic signed [PXW-1:0]   px;
    logic signed [QBW-1:0]   r_qb;
    logic signed [QXW-1:0]   r_qx;

    // Stages 6 to 8: projected length times axis.
    logic signed [QBW+VW-1:0] pq_b [3];
    logic signed [QXW+VW-1:0] pq_x [3];
    logic signed [SBW-1:0]    sh_b [3];
    logic signed [SXW-1:0]    sh_x [3];

    // Stage 9: components across the axis.
    logic signed [BPW-1:0]   r_bp [3];
    logic signed [XPW-1:0]   r_xp [3];
    logic [3*(BW_IN+XW)-1:0] bx_dly;
    logic signed [BW_IN-1:0] d_b [3];
    logic signed [XW-1:0]    d_x [3];

    // Stages 10 to 12: squares and cross products.
    logic signed [2*BPW-1:0]   m_aa [3];
    logic signed [BPW+XPW-1:0] m_hh [3];
    logic signed [2*XPW-1:0]   m_cc [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            rci_mul #(.AW(BW_IN), .BW(VW)) u_mul_pb (
                .i_clk(i_clk), .i_en(en), .i_a(r_b[g]), .i_b(r_axis[g]), .o_p(p_b[g])
            );
            rci_mul #(.AW(XW), .BW(VW)) u_mul_px (
                .i_clk(i_clk), .i_en(en), .i_a(r_x[g]), .i_b(r_axis[g]), .o_p(p_x[g])
            );
            rci_mul #(.AW(QBW), .BW(VW)) u_mul_qb (
                .i_clk(i_clk), .i_en(en), .i_a(r_qb), .i_b(r_axis[g]), .o_p(pq_b[g])
            );
            rci_mul #(.AW(QXW), .BW(VW)) u_mul_qx (
                .i_clk(i_clk), .i_en(en), .i_a(r_qx), .i_b(r_axis[g]), .o_p(pq_x[g])
            );
            rci_mul #(.AW(BPW), .BW(BPW)) u_mul_aa (
                .i_clk(i_clk), .i_en(en), .i_a(r_bp[g]), .i_b(r_bp[g]), .o_p(m_aa[g])
            );
            rci_mul #(.AW(BPW), .BW(XPW)) u_mul_hh (
                .i_clk(i_clk), .i_en(en), .i_a(r_bp[g]), .i_b(r_xp[g]), .o_p(m_hh[g])
            );
            rci_mul #(.AW(XPW), .BW(XPW)) u_mul_cc (
                .i_clk(i_clk), .i_en(en), .i_a(r_xp[g]), .i_b(r_xp[g]), .o_p(m_cc[g])
            );

            // Arithmetic shift right is the floor of the scaled product.
            assign sh_b[g] = pq_b[g][QBW+VW-1:FRAC_BITS];
            assign sh_x[g] = pq_x[g][QXW+VW-1:FRAC_BITS];
            assign d_b[g]  = bx_dly[3*XW + g*BW_IN +: BW_IN];
            assign d_x[g]  = bx_dly[g*XW +: XW];
        end
    endgenerate

    assign pb = PBW'(p_b[0]) + PBW'(p_b[1]) + PBW'(p_b[2]);
    assign px = PXW'(p_x[0]) + PXW'(p_x[1]) + PXW'(p_x[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qb <= pb[PBW-1:FRAC_BITS];
            r_qx <= px[PXW-1:FRAC_BITS];
        end
    end

    // Direction and offset wait seven stages for the projection.
    rci_dly #(.W(3*(BW_IN+XW)), .N(7)) u_dly_bx (
        .i_clk(i_clk),
        .i_en (en),
        .i_d  ({r_b[2], r_b[1], r_b[0], r_x[2], r_x[1], r_x[0]}),
        .o_q  (bx_dly)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_bp[i] <= BPW'(d_b[i]) - BPW'(sh_b[i]);
                r_xp[i] <= XPW'(d_x[i]) - XPW'(sh_x[i]);
            end
        end
    end

    // Stage 13: quadratic coefficients a, h and c.
    logic signed [AQW-1:0] r_a;
    logic signed [HQW-1:0] r_h;
    logic signed [CQW-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= AQW'(m_aa[0]) + AQW'(m_aa[1]) + AQW'(m_aa[2]);
            r_h <= HQW'(m_hh[0]) + HQW'(m_hh[1]) + HQW'(m_hh[2]);
            r_c <= CQW'(m_cc[0]) + CQW'(m_cc[1]) + CQW'(m_cc[2])
                 - CQW'(signed'({1'b0, r_rad_sq}));
        end
    end

    // Stages 14 to 16: h squared and a times c.
    logic signed [2*HQW-1:0]   m_h2;
    logic signed [AQW+CQW-1:0] m_ac;
    logic [HQW+AQW-1:0]        ha_dly;
    logic signed [HQW-1:0]     dly_h;
    logic [AQW-1:0]            dly_a;

    rci_mul #(.AW(HQW), .BW(HQW)) u_mul_h2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_h), .i_b(r_h), .o_p(m_h2)
    );
    rci_mul #(.AW(AQW), .BW(CQW)) u_mul_ac (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .i_b(r_c), .o_p(m_ac)
    );
    rci_dly #(.W(HQW+AQW), .N(3)) u_dly_ha (
        .i_clk(i_clk), .i_en(en), .i_d({r_h, r_a}), .o_q(ha_dly)
    );

    assign dly_h = ha_dly[HQW+AQW-1:AQW];
    assign dly_a = ha_dly[AQW-1:0];

    // Stage 17: discriminant and status. A zero a is tested before the sign of D.
    logic signed [DW-1:0] disc;
    logic [2*SQW-1:0]     r_rad;
    logic [PLW-1:0]       r_pl;

    assign disc = DW'(m_h2) - DW'(m_ac);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= disc[DW-1] ? '0 : disc[2*SQW-1:0];
            r_pl  <= {dly_h, dly_a[DVW-1:0], (dly_a == '0), disc[DW-1]};
        end
    end

    // Square root row: cell k settles root bit SQW-1-k.
    logic [2*SQW-1:0] w_rad  [SQW+1];
    logic [SQW+1:0]   w_rem  [SQW+1];
    logic [SQW-1:0]   w_root [SQW+1];
    logic [PLW-1:0]   w_pl   [SQW+1];

    assign w_rad[0]  = r_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_pl[0]   = r_pl;

    generate
        for (g = 0; g < SQW; g++) begin : g_sqrt
            rci_sqrt_cell #(.SQW(SQW), .PLW(PLW)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_rad (w_rad[g]),
                .i_rem (w_rem[g]),
                .i_root(w_root[g]),
                .i_pl  (w_pl[g]),
                .o_rad (w_rad[g+1]),
                .o_rem (w_rem[g+1]),
                .o_root(w_root[g+1]),
                .o_pl  (w_pl[g+1])
            );
        end
    endgenerate

    logic signed [HQW-1:0] sq_h;
    logic [DVW-1:0]        sq_a;
    logic signed [NW-1:0]  root_s;

    assign sq_h   = w_pl[SQW][PLW-1 -: HQW];
    assign sq_a   = w_pl[SQW][2 +: DVW];
    assign root_s = NW'(signed'({1'b0, w_root[SQW]}));

    // Numerators -h + S and -h - S, then sign and magnitude, then overflow test.
    logic signed [NW-1:0] r_np;
    logic signed [NW-1:0] r_nm;
    logic [DVW-1:0]       r_x1_a;
    logic                 r_x1_par;
    logic                 r_x1_miss;
    logic [NW-1:0]        r_magp;
    logic [NW-1:0]        r_magm;
    logic [DVW-1:0]       r_x2_a;
    t_root_flags          r_x2_flags;
    logic [RW-1:0]        r_remp;
    logic [RW-1:0]        r_remm;
    logic [DVW-1:0]       r_x3_a;
    t_root_flags          r_x3_flags;
    logic [RW-1:0]        shp;
    logic [RW-1:0]        shm;
    logic [RW-1:0]        lim;

    assign shp = RW'({r_magp, {FRAC_BITS{1'b0}}});
    assign shm = RW'({r_magm, {FRAC_BITS{1'b0}}});
    assign lim = RW'(r_x2_a) << QBITS;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_np      <= root_s - NW'(sq_h);
            r_nm      <= -NW'(sq_h) - root_s;
            r_x1_a    <= sq_a;
            r_x1_par  <= w_pl[SQW][1];
            r_x1_miss <= w_pl[SQW][0];

            r_magp           <= r_np[NW-1] ? $unsigned(-r_np) : $unsigned(r_np);
            r_magm           <= r_nm[NW-1] ? $unsigned(-r_nm) : $unsigned(r_nm);
            r_x2_a           <= r_x1_a;
            r_x2_flags.par   <= r_x1_par;
            r_x2_flags.miss  <= r_x1_miss;
            r_x2_flags.ovf_p <= 1'b0;
            r_x2_flags.ovf_m <= 1'b0;
            r_x2_flags.neg_p <= r_np[NW-1];
            r_x2_flags.neg_m <= r_nm[NW-1];

            // A quotient of 2^31 or more saturates, so only 31 bits are divided.
            r_remp     <= shp;
            r_remm     <= shm;
            r_x3_a     <= r_x2_a;
            r_x3_flags <= '{par:   r_x2_flags.par,
                            miss:  r_x2_flags.miss,
                            ovf_p: (shp >= lim),
                            ovf_m: (shm >= lim),
                            neg_p: r_x2_flags.neg_p,
                            neg_m: r_x2_flags.neg_m};
        end
    end

    // Division rows, one quotient bit per cell, most significant first.
    logic [RW-1:0]    w_remp [QBITS+1];
    logic [RW-1:0]    w_remm [QBITS+1];
    logic [DVW-1:0]   w_dvsp [QBITS+1];
    logic [DVW-1:0]   w_dvsm [QBITS+1];
    logic [QBITS-1:0] w_qp   [QBITS+1];
    logic [QBITS-1:0] w_qm   [QBITS+1];
    t_root_flags      fin_flags;

    assign w_remp[0] = r_remp;
    assign w_remm[0] = r_remm;
    assign w_dvsp[0] = r_x3_a;
    assign w_dvsm[0] = r_x3_a;
    assign w_qp[0]   = '0;
    assign w_qm[0]   = '0;

    generate
        for (g = 0; g < QBITS; g++) begin : g_div
            rci_div_cell #(.RW(RW), .DVW(DVW), .K(QBITS-1-g)) u_cell_p (
                .i_clk(i_clk), .i_en(en),
                .i_rem(w_remp[g]), .i_dvs(w_dvsp[g]), .i_q(w_qp[g]),
                .o_rem(w_remp[g+1]), .o_dvs(w_dvsp[g+1]), .o_q(w_qp[g+1])
            );
            rci_div_cell #(.RW(RW), .DVW(DVW), .K(QBITS-1-g)) u_cell_m (
                .i_clk(i_clk), .i_en(en),
                .i_rem(w_remm[g]), .i_dvs(w_dvsm[g]), .i_q(w_qm[g]),
                .o_rem(w_remm[g+1]), .o_dvs(w_dvsm[g+1]), .o_q(w_qm[g+1])
            );
        end
    endgenerate

    rci_dly #(.W(FLW), .N(QBITS)) u_dly_flags (
        .i_clk(i_clk), .i_en(en), .i_d(r_x3_flags), .o_q(fin_flags)
    );

    // Result word.
    t_hit fin_hit;

    always_comb begin
        if (fin_flags.par || fin_flags.miss) begin
            fin_hit.t_plus     = MISS_DISTANCE;
            fin_hit.t_minus    = MISS_DISTANCE;
            fin_hit.hit_status = fin_flags.par ? ST_PARALLEL : ST_MISS;
        end else begin
            fin_hit.t_plus     = root_word(w_qp[QBITS], fin_flags.ovf_p, fin_flags.neg_p);
            fin_hit.t_minus    = root_word(w_qm[QBITS], fin_flags.ovf_m, fin_flags.neg_m);
            fin_hit.hit_status = ST_HIT;
        end
    end

    // Two-entry output queue. The pipeline moves whenever an entry is free.
    t_hit       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign en          = (r_cnt != 2'd2);
    assign o_ray_ready = en;
    assign ray_acc     = i_ray_valid && en;
    assign push        = en && r_vld[LAT-1];
    assign pop         = o_hit_valid && i_hit_ready;
    assign o_hit_valid = (r_cnt != 2'd0);
    assign o_hit       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], ray_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= fin_hit;
        end
    end

    // The queue never holds more than two results.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("output queue count out of range");

    // A miss or a parallel ray carries the miss distance in both roots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && o_hit.hit_status != ST_HIT) |->
        (o_hit.t_plus == MISS_DISTANCE && o_hit.t_minus == MISS_DISTANCE))
        else $error("non-hit result without miss distance");

    // For a hit, a is positive, so the plus root never lies below the minus root.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && o_hit.hit_status == ST_HIT) |-> (o_hit.t_plus >= o_hit.t_minus))
        else $error("root order reversed");

    // Reset empties the queue.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_hit_valid)
        else $error("result pending after reset");

endmodule
